// File: sv/hkt_pkg.sv
// Shared types and constants for the held-key tracker.
// No dependencies; imported by every module of the block.
`default_nettype none

package hkt_pkg;

    // Key range and bitmap geometry
    localparam int NUM_KEYS     = 256;
    localparam int KEYS_TRACKED = (NUM_KEYS < 256) ? NUM_KEYS : 256;
    localparam int NUM_WORDS    = (KEYS_TRACKED + 63) / 64;
    localparam int WORD_SLOTS   = 4;

    // Command codes
    localparam logic [1:0] CMD_PAUSE   = 2'd0;
    localparam logic [1:0] CMD_RECORD  = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    // Pause recogniser verdicts
    localparam logic [1:0] VERDICT_FOREIGN = 2'd0;
    localparam logic [1:0] VERDICT_SWALLOW = 2'd1;
    localparam logic [1:0] VERDICT_PAUSE   = 2'd2;

    // Recogniser steps
    localparam logic [1:0] STEP_IDLE      = 2'd0;
    localparam logic [1:0] STEP_CTRL_DN   = 2'd1;
    localparam logic [1:0] STEP_NUMLK_DN  = 2'd2;
    localparam logic [1:0] STEP_CTRL_UP   = 2'd3;

    // Scancodes of the Pause sequence
    localparam logic [7:0] SC_CTRL    = 8'h1D;
    localparam logic [7:0] SC_NUMLOCK = 8'h45;

    // Input transaction
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] scancode;
        logic       extended1;
        logic       pressed;
        logic [7:0] key_code;
    } hkt_in_t;

    // Result transaction
    typedef struct packed {
        logic [1:0]  pause_verdict;
        logic        accepted;
        logic [1:0]  word_index;
        logic [63:0] held_mask;
        logic        last;
    } hkt_out_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic dump;
    } hkt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_word;
    } hkt_stat_t;

endpackage

`default_nettype wire

// File: sv/hkt_ctrl.sv
// Controller state machine for the held-key tracker.
// Depends on hkt_pkg; drives hkt_datapath through hkt_cmd_t.
`default_nettype none

module hkt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [1:0]        start_cmd,
    input  wire hkt_pkg::hkt_stat_t stat,
    output hkt_pkg::hkt_cmd_t      cmd,
    output logic                   busy
);
    import hkt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DUMP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_next;
    logic   busy_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (start_cmd) inside
                        CMD_PAUSE, CMD_RECORD: state_next = ST_EXEC;
                        CMD_RELEASE:           state_next = ST_DUMP;
                        default:               state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            ST_DUMP:
            begin
                if (stat.last_word)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        busy_next = (state_next != ST_IDLE);
    end

    // State and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    // Commands to the datapath
    always_comb
    begin
        cmd.load = (state_reg == ST_IDLE) && start;
        cmd.exec = (state_reg == ST_EXEC);
        cmd.dump = (state_reg == ST_DUMP);
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

// File: sv/hkt_datapath.sv
// Datapath: item register, Pause recogniser, held-key bitmap, result register.
// Depends on hkt_pkg; commanded by hkt_ctrl.
`default_nettype none

module hkt_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hkt_pkg::hkt_in_t  item,
    input  wire hkt_pkg::hkt_cmd_t cmd,
    output hkt_pkg::hkt_stat_t     stat,
    output hkt_pkg::hkt_out_t      result,
    output logic                   valid
);
    import hkt_pkg::*;

    localparam logic [8:0] KEY_LIMIT = 9'(KEYS_TRACKED);
    localparam logic [1:0] LAST_IDX  = 2'(NUM_WORDS - 1);

    hkt_in_t     item_reg;
    logic [1:0]  step_reg;
    logic [1:0]  step_next;
    logic [63:0] held_reg [WORD_SLOTS];
    logic [63:0] held_next [WORD_SLOTS];
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    hkt_out_t    result_reg;
    hkt_out_t    result_next;
    logic        valid_reg;
    logic        valid_next;

    logic [1:0]  rd_idx;
    logic [63:0] rd_word;
    logic [63:0] bit_mask;
    logic        key_ok;
    logic        bit_set;
    logic [1:0]  verdict;
    logic [1:0]  step_after;
    logic        rec_ok;

    // Bitmap read port: dump walks the counter, record uses the key's word
    always_comb
    begin
        rd_idx   = cmd.dump ? cnt_reg : item_reg.key_code[7:6];
        rd_word  = held_reg[rd_idx];
        bit_mask = 64'd1 << item_reg.key_code[5:0];
        bit_set  = |(rd_word & bit_mask);
        key_ok   = ({1'b0, item_reg.key_code} < KEY_LIMIT);
        rec_ok   = key_ok && (item_reg.pressed ? !bit_set : bit_set);
    end

    assign stat.last_word = (cnt_reg == LAST_IDX);

    // Pause recogniser; a broken sequence falls back to idle as foreign
    always_comb
    begin
        verdict    = VERDICT_FOREIGN;
        step_after = STEP_IDLE;
        unique case (step_reg)
            STEP_IDLE:
            begin
                if (item_reg.extended1 && item_reg.scancode == SC_CTRL && item_reg.pressed)
                begin
                    verdict    = VERDICT_SWALLOW;
                    step_after = STEP_CTRL_DN;
                end
            end
            STEP_CTRL_DN:
            begin
                if (item_reg.scancode == SC_NUMLOCK && item_reg.pressed)
                begin
                    verdict    = VERDICT_SWALLOW;
                    step_after = STEP_NUMLK_DN;
                end
            end
            STEP_NUMLK_DN:
            begin
                if (item_reg.scancode == SC_CTRL && !item_reg.pressed)
                begin
                    verdict    = VERDICT_SWALLOW;
                    step_after = STEP_CTRL_UP;
                end
            end
            STEP_CTRL_UP:
            begin
                if (item_reg.scancode == SC_NUMLOCK && !item_reg.pressed)
                begin
                    verdict    = VERDICT_PAUSE;
                    step_after = STEP_IDLE;
                end
            end
            default:
            begin
                verdict    = VERDICT_FOREIGN;
                step_after = STEP_IDLE;
            end
        endcase
    end

    // Next-state of the datapath registers
    always_comb
    begin
        step_next   = step_reg;
        held_next   = held_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        valid_next  = 1'b0;

        if (cmd.load)
        begin
            cnt_next = 2'd0;
        end

        if (cmd.exec)
        begin
            valid_next                = 1'b1;
            result_next.pause_verdict = VERDICT_FOREIGN;
            result_next.accepted      = 1'b0;
            result_next.word_index    = 2'd0;
            result_next.held_mask     = 64'd0;
            result_next.last          = 1'b1;
            if (item_reg.cmd == CMD_PAUSE)
            begin
                result_next.pause_verdict = verdict;
                step_next                 = step_after;
            end
            else
            begin
                result_next.accepted = rec_ok;
                if (rec_ok)
                begin
                    held_next[rd_idx] = rd_word ^ bit_mask;
                end
            end
        end

        // Release all: report one word per cycle and clear it
        if (cmd.dump)
        begin
            valid_next                = 1'b1;
            result_next.pause_verdict = VERDICT_FOREIGN;
            result_next.accepted      = 1'b0;
            result_next.word_index    = cnt_reg;
            result_next.held_mask     = rd_word;
            result_next.last          = stat.last_word;
            held_next[rd_idx]         = 64'd0;
            cnt_next                  = cnt_reg + 2'd1;
            step_next                 = STEP_IDLE;
        end
    end

    // Item and result registers (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        result_reg <= result_next;
    end

    // Control state and bitmap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= STEP_IDLE;
            cnt_reg   <= 2'd0;
            valid_reg <= 1'b0;
            for (int i = 0; i < WORD_SLOTS; i++)
            begin
                held_reg[i] <= 64'd0;
            end
        end
        else
        begin
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            held_reg  <= held_next;
        end
    end

    assign result = result_reg;
    assign valid  = valid_reg;

endmodule

`default_nettype wire

// File: sv/held_key_tracker_with_pause_sequence.sv
// Top level of the held-key tracker with Pause-sequence recogniser.
// Depends on hkt_pkg, hkt_ctrl and hkt_datapath.
//
// Channel   Direction  Handshake                 Payload
// item      in         start & !busy accepts     hkt_in_t
// result    out        valid, one cycle, no hold hkt_out_t
//
// A pause check or key record captures the item, evaluates it in the EXEC state,
// and shows the result in the cycle after. Release-all captures the item, then
// reports and clears the bitmap words in turn (NUM_WORDS), walking the bitmap
// through its single read port. Unused command 3 is dropped on accept.
// Asynchronous active-low reset clears the bitmap and the recogniser at once.
// The receiver cannot stall; each result is valid for exactly one cycle.
`default_nettype none

module held_key_tracker_with_pause_sequence (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire hkt_pkg::hkt_in_t item,
    output hkt_pkg::hkt_out_t     result,
    output logic                  valid
);
    import hkt_pkg::*;

    hkt_cmd_t  dp_cmd;
    hkt_stat_t dp_stat;

    // Sequencer
    hkt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .start_cmd (item.cmd),
        .stat      (dp_stat),
        .cmd       (dp_cmd),
        .busy      (busy)
    );

    // Bitmap, recogniser and result register
    hkt_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (dp_cmd),
        .stat   (dp_stat),
        .result (result),
        .valid  (valid)
    );

endmodule

`default_nettype wire
